FILE: rtl/bps_pkg.sv
// Shared constants, types and helpers for the Blinn-Phong fragment shader.
package bps_pkg;

	// Default colour channel width.
	localparam int COLOR_BITS_DEF = 8;

	// Vector component width before normalization (Q8.8 differences, 17 bits).
	localparam int VW = 17;
	// Unit vector component width (signed Q1.14).
	localparam int UW = 16;
	// Width of a sum of three squared components.
	localparam int SQW = 34;
	// Quotient bits of the normalizing division.
	localparam int QW = 15;

	localparam int ONE_Q14     = 16384;
	localparam int AMBIENT_Q14 = 3277;
	localparam int ROUND_Q14   = 8192;
	localparam int FRAC_Q14    = 14;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_LIGHT_X = 3'd0;
	localparam logic [2:0] REG_LIGHT_Y = 3'd1;
	localparam logic [2:0] REG_LIGHT_Z = 3'd2;
	localparam logic [2:0] REG_EYE_X   = 3'd3;
	localparam logic [2:0] REG_EYE_Y   = 3'd4;
	localparam logic [2:0] REG_EYE_Z   = 3'd5;

	typedef logic [2:0][VW-1:0] vec_t;
	typedef logic [2:0][UW-1:0] uvec_t;

	// Clamp a Q2.28 dot product to a rounded, non-negative Q1.14 value.
	function automatic logic [QW-1:0] dot_cap(input logic signed [31:0] s);
		logic signed [31:0] t;
		t = (s + 32'(ROUND_Q14)) >>> FRAC_Q14;
		if (s <= 32'sd0) begin
			return '0;
		end else if (t > 32'(ONE_Q14)) begin
			return QW'(ONE_Q14);
		end
		return t[QW-1:0];
	endfunction

	// Round a squared Q1.14 value back to Q1.14 and cap it at one.
	function automatic logic [QW-1:0] sq_round(input logic [2*QW-1:0] p);
		logic [2*QW-1:0] t;
		t = (p + (2*QW)'(ROUND_Q14)) >> FRAC_Q14;
		if (t > (2*QW)'(ONE_Q14)) begin
			return QW'(ONE_Q14);
		end
		return t[QW-1:0];
	endfunction

endpackage

FILE: rtl/bps_norm.sv
// Pipelined vector normalizer: sum of squares, bit-per-stage square root,
// then a bit-per-stage division of each component by the length.
module bps_norm #(
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  bps_pkg::vec_t       v,
	input  logic [SW-1:0]       side_i,
	output logic                out_valid,
	output bps_pkg::uvec_t      u,
	output logic                ok,
	output logic [SW-1:0]       side_o
);
	localparam int VW   = bps_pkg::VW;
	localparam int UW   = bps_pkg::UW;
	localparam int SQW  = bps_pkg::SQW;
	localparam int AW   = SQW + 16;
	localparam int RW   = AW / 2;
	localparam int REMW = RW + 3;
	localparam int QW   = bps_pkg::QW;
	localparam int NW   = VW + 23;

	// Stage 1: squares and magnitudes.
	logic [2:0][2*VW-2:0] sq_s1;
	logic [2:0][VW-1:0]   mag_s1;
	logic [2:0]           neg_s1;
	logic [SW-1:0]        side_s1;
	logic                 v_s1;
	logic [2:0][2*VW-2:0] sq_c;
	logic [2:0][VW-1:0]   mag_c;

	always_comb begin
		logic signed [2*VW-1:0] p;
		for (int i = 0; i < 3; i++) begin
			p = $signed(v[i]) * $signed(v[i]);
			sq_c[i] = p[2*VW-2:0];
			mag_c[i] = v[i][VW-1] ? (~v[i] + VW'(1)) : v[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= sq_c;
			mag_s1  <= mag_c;
			neg_s1  <= {v[2][VW-1], v[1][VW-1], v[0][VW-1]};
			side_s1 <= side_i;
		end
	end

	// Stage 2: sum of squares.
	logic [SQW-1:0]     sum_s2;
	logic [2:0][VW-1:0] mag_s2;
	logic [2:0]         neg_s2;
	logic [SW-1:0]      side_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= SQW'(sq_s1[0]) + SQW'(sq_s1[1]) + SQW'(sq_s1[2]);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// Square root of the sum scaled by 2^16, one result bit per stage.
	logic [AW-1:0]       ia_s    [0:RW];
	logic [REMW-1:0]     irem_s  [0:RW];
	logic [RW-1:0]       iroot_s [0:RW];
	logic [2:0][VW-1:0]  imag_s  [0:RW];
	logic [2:0]          ineg_s  [0:RW];
	logic                izero_s [0:RW];
	logic [SW-1:0]       iside_s [0:RW];
	logic                iv_s    [0:RW];

	assign ia_s[0]    = {sum_s2, 16'b0};
	assign irem_s[0]  = '0;
	assign iroot_s[0] = '0;
	assign imag_s[0]  = mag_s2;
	assign ineg_s[0]  = neg_s2;
	assign izero_s[0] = (sum_s2 == '0);
	assign iside_s[0] = side_s2;
	assign iv_s[0]    = v_s2;

	for (genvar k = 1; k <= RW; k++) begin : g_sqrt
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		logic            ge;

		assign rem_sh = {irem_s[k-1][REMW-3:0], ia_s[k-1][AW-1:AW-2]};
		assign trial  = {1'b0, iroot_s[k-1], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				irem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				iroot_s[k] <= {iroot_s[k-1][RW-2:0], ge};
				ia_s[k]    <= {ia_s[k-1][AW-3:0], 2'b00};
				imag_s[k]  <= imag_s[k-1];
				ineg_s[k]  <= ineg_s[k-1];
				izero_s[k] <= izero_s[k-1];
				iside_s[k] <= iside_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iv_s[k] <= 1'b0;
			end else if (en) begin
				iv_s[k] <= iv_s[k-1];
			end
		end
	end

	// Division of each scaled magnitude by the length, one quotient bit per stage.
	logic [2:0][NW-1:0] drem_s  [0:QW];
	logic [2:0][QW-1:0] dq_s    [0:QW];
	logic [RW-1:0]      dr_s    [0:QW];
	logic [2:0]         dneg_s  [0:QW];
	logic               dzero_s [0:QW];
	logic [SW-1:0]      dside_s [0:QW];
	logic               dv_s    [0:QW];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_s[0][i] <= (NW'(imag_s[RW][i]) << 22) + NW'(iroot_s[RW] >> 1);
			end
			dq_s[0]    <= '0;
			dr_s[0]    <= iroot_s[RW];
			dneg_s[0]  <= ineg_s[RW];
			dzero_s[0] <= izero_s[RW];
			dside_s[0] <= iside_s[RW];
		end
	end

	for (genvar m = 1; m <= QW; m++) begin : g_div
		logic [NW-1:0] dsor;
		logic [2:0]    ge;

		assign dsor = NW'(dr_s[m-1]) << (QW - m);
		for (genvar i = 0; i < 3; i++) begin : g_cmp
			assign ge[i] = (drem_s[m-1][i] >= dsor);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem_s[m][i] <= ge[i] ? (drem_s[m-1][i] - dsor) : drem_s[m-1][i];
					dq_s[m][i]   <= {dq_s[m-1][i][QW-2:0], ge[i]};
				end
				dr_s[m]    <= dr_s[m-1];
				dneg_s[m]  <= dneg_s[m-1];
				dzero_s[m] <= dzero_s[m-1];
				dside_s[m] <= dside_s[m-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[m] <= 1'b0;
			end else if (en) begin
				dv_s[m] <= dv_s[m-1];
			end
		end
	end

	// Final stage: cap at one, restore the sign, zero a degenerate vector.
	bps_pkg::uvec_t u_sf;
	logic           ok_sf;
	logic [SW-1:0]  side_sf;
	logic           v_sf;

	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				q = (dq_s[QW][i] > QW'(bps_pkg::ONE_Q14)) ? QW'(bps_pkg::ONE_Q14)
				                                          : dq_s[QW][i];
				if (dzero_s[QW]) begin
					u_sf[i] <= '0;
				end else if (dneg_s[QW][i]) begin
					u_sf[i] <= -UW'(q);
				end else begin
					u_sf[i] <= UW'(q);
				end
			end
			ok_sf   <= ~dzero_s[QW];
			side_sf <= dside_s[QW];
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			dv_s[0] <= 1'b0;
			v_sf    <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			dv_s[0] <= iv_s[RW];
			v_sf    <= dv_s[QW];
		end
	end

	assign out_valid = v_sf;
	assign u         = u_sf;
	assign ok        = ok_sf;
	assign side_o    = side_sf;

endmodule

FILE: rtl/bps_shade.sv
// Pipelined lighting: dot products, specular power by three squarings,
// lighting factor times texel and saturation.
module bps_shade #(
	parameter int CB = bps_pkg::COLOR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  bps_pkg::uvec_t      nu,
	input  bps_pkg::uvec_t      lu,
	input  bps_pkg::uvec_t      hu,
	input  logic                ok,
	input  logic [2:0][CB-1:0]  tex,
	output logic                out_valid,
	output logic [2:0][CB-1:0]  rgb,
	output logic                degenerate
);
	localparam int QW = bps_pkg::QW;
	localparam int PW = CB + 16;
	localparam logic [CB-1:0] COLOR_MAX = '1;

	// Stage 1: component products of N.L and N.H.
	logic signed [2:0][31:0] pl_s1;
	logic signed [2:0][31:0] ph_s1;
	logic                    ok_s1;
	logic [2:0][CB-1:0]      tex_s1;
	logic                    v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i] <= 32'($signed(nu[i]) * $signed(lu[i]));
				ph_s1[i] <= 32'($signed(nu[i]) * $signed(hu[i]));
			end
			ok_s1  <= ok;
			tex_s1 <= tex;
		end
	end

	// Stage 2: clamped dot products.
	logic [QW-1:0]      dl_s2;
	logic [QW-1:0]      dh_s2;
	logic               ok_s2;
	logic [2:0][CB-1:0] tex_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s2  <= bps_pkg::dot_cap(pl_s1[0] + pl_s1[1] + pl_s1[2]);
			dh_s2  <= bps_pkg::dot_cap(ph_s1[0] + ph_s1[1] + ph_s1[2]);
			ok_s2  <= ok_s1;
			tex_s2 <= tex_s1;
		end
	end

	// Specular power: three squarings, each a multiply stage and a round stage.
	logic [2*QW-1:0]    sp_s [0:2];
	logic [QW-1:0]      dp_s [0:3];
	logic [QW-1:0]      cdl_s  [0:6];
	logic               cok_s  [0:6];
	logic [2:0][CB-1:0] ctex_s [0:6];
	logic               cv_s   [0:6];

	assign dp_s[0]   = dh_s2;
	assign cdl_s[0]  = dl_s2;
	assign cok_s[0]  = ok_s2;
	assign ctex_s[0] = tex_s2;
	assign cv_s[0]   = v_s2;

	for (genvar k = 0; k < 3; k++) begin : g_pow
		always_ff @(posedge clk) begin
			if (en) begin
				sp_s[k]   <= (2*QW)'(dp_s[k]) * (2*QW)'(dp_s[k]);
				dp_s[k+1] <= bps_pkg::sq_round(sp_s[k]);
			end
		end
	end

	for (genvar c = 1; c <= 6; c++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en) begin
				cdl_s[c]  <= cdl_s[c-1];
				cok_s[c]  <= cok_s[c-1];
				ctex_s[c] <= ctex_s[c-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[c] <= 1'b0;
			end else if (en) begin
				cv_s[c] <= cv_s[c-1];
			end
		end
	end

	// Lighting factor: ambient alone when any vector was degenerate.
	logic [15:0] f;

	assign f = cok_s[6] ? (16'(bps_pkg::AMBIENT_Q14) + 16'(cdl_s[6]) + 16'(dp_s[3]))
	                    : 16'(bps_pkg::AMBIENT_Q14);

	// Stage 9: texel times factor.
	logic [2:0][PW-1:0] cp_s9;
	logic               ok_s9;
	logic               v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cp_s9[i] <= PW'(ctex_s[6][i]) * PW'(f);
			end
			ok_s9 <= cok_s[6];
		end
	end

	// Stage 10: round, saturate and hold the word for the output.
	logic [2:0][CB-1:0] rgb_s10;
	logic               deg_s10;
	logic               v_s10;

	always_ff @(posedge clk) begin
		logic [PW:0] t;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t = ((PW+1)'(cp_s9[i]) + (PW+1)'(bps_pkg::ROUND_Q14)) >> bps_pkg::FRAC_Q14;
				rgb_s10[i] <= (t > (PW+1)'(COLOR_MAX)) ? COLOR_MAX : t[CB-1:0];
			end
			deg_s10 <= ~ok_s9;
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s9  <= cv_s[6];
			v_s10 <= v_s9;
		end
	end

	assign out_valid  = v_s10;
	assign rgb        = rgb_s10;
	assign degenerate = deg_s10;

endmodule

FILE: rtl/blinn_phong_fragment_shade.sv
// Blinn-Phong fragment shader, fully pipelined.
// Path: input stage, then two 44-stage normalizers in series (most of their stages
// are square-root and divider stages) with the half-vector stage between them, then lighting.
// Throughput: one fragment per cycle; the whole pipeline holds while an output word waits.
// Reset: arst_n clears all valid bits and the light and eye registers to zero.
module blinn_phong_fragment_shade #(
	parameter int COLOR_BITS = bps_pkg::COLOR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, texel_r, texel_g, texel_b
	input  logic [((96+3*COLOR_BITS+7)/8)*8-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_r, out_g, out_b
	output logic [((3*COLOR_BITS+7)/8)*8-1:0]     m_tdata,
	// degenerate
	output logic                                  m_tuser,
	input  logic                                  cfg_we,
	input  logic [2:0]                            cfg_index,
	input  logic [15:0]                           cfg_data
);
	localparam int CB    = COLOR_BITS;
	localparam int OUT_W = ((3*CB+7)/8)*8;
	localparam int UW    = bps_pkg::UW;
	localparam int HSW   = 6*UW + 3*CB + 1;

	// Configuration registers.
	logic [15:0] light_x_q, light_y_q, light_z_q;
	logic [15:0] eye_x_q, eye_y_q, eye_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= '0;
			eye_x_q   <= '0;
			eye_y_q   <= '0;
			eye_z_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bps_pkg::REG_LIGHT_X: light_x_q <= cfg_data;
				bps_pkg::REG_LIGHT_Y: light_y_q <= cfg_data;
				bps_pkg::REG_LIGHT_Z: light_z_q <= cfg_data;
				bps_pkg::REG_EYE_X:   eye_x_q   <= cfg_data;
				bps_pkg::REG_EYE_Y:   eye_y_q   <= cfg_data;
				bps_pkg::REG_EYE_Z:   eye_z_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or being taken.
	logic en;

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	// Unpack the input word.
	logic [2:0][15:0]   pos;
	logic [2:0][15:0]   nrm;
	logic [2:0][CB-1:0] tex;
	logic [2:0][15:0]   lpos;
	logic [2:0][15:0]   epos;

	assign lpos = {light_z_q, light_y_q, light_x_q};
	assign epos = {eye_z_q, eye_y_q, eye_x_q};

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign pos[i] = s_tdata[16*i +: 16];
		assign nrm[i] = s_tdata[48 + 16*i +: 16];
		assign tex[i] = s_tdata[96 + CB*i +: CB];
	end

	// Stage 1: light and view directions, normal widened.
	bps_pkg::vec_t      nv_s1, lv_s1, vv_s1;
	logic [2:0][CB-1:0] tex_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nv_s1[i] <= {nrm[i][15], nrm[i]};
				lv_s1[i] <= {lpos[i][15], lpos[i]} - {pos[i][15], pos[i]};
				vv_s1[i] <= {epos[i][15], epos[i]} - {pos[i][15], pos[i]};
			end
			tex_s1 <= tex;
		end
	end

	// First normalizing pass: N, L and V side by side.
	bps_pkg::uvec_t     nu, lu, vu;
	logic               n_ok, l_ok, v_ok;
	logic               n_valid;
	logic [3*CB-1:0]    n_side;

	bps_norm #(.SW(3*CB)) u_norm_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.v         (nv_s1),
		.side_i    (tex_s1),
		.out_valid (n_valid),
		.u         (nu),
		.ok        (n_ok),
		.side_o    (n_side)
	);

	bps_norm #(.SW(1)) u_norm_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.v         (lv_s1),
		.side_i    (1'b0),
		.out_valid (),
		.u         (lu),
		.ok        (l_ok),
		.side_o    ()
	);

	bps_norm #(.SW(1)) u_norm_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.v         (vv_s1),
		.side_i    (1'b0),
		.out_valid (),
		.u         (vu),
		.ok        (v_ok),
		.side_o    ()
	);

	// Stage 2: half vector, with N, L, the texel and the flag riding along.
	bps_pkg::vec_t  hv_s2;
	logic [HSW-1:0] hside_s2;
	logic           v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hv_s2[i] <= {lu[i][UW-1], lu[i]} + {vu[i][UW-1], vu[i]};
			end
			hside_s2 <= {n_ok & l_ok & v_ok, n_side, lu, nu};
		end
	end

	// Second normalizing pass: H.
	bps_pkg::uvec_t hu;
	logic           h_ok;
	logic           h_valid;
	logic [HSW-1:0] h_side;

	bps_norm #(.SW(HSW)) u_norm_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.v         (hv_s2),
		.side_i    (hside_s2),
		.out_valid (h_valid),
		.u         (hu),
		.ok        (h_ok),
		.side_o    (h_side)
	);

	// Lighting and colour.
	logic [2:0][CB-1:0] rgb;

	bps_shade #(.CB(CB)) u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (h_valid),
		.nu         (h_side[3*UW-1:0]),
		.lu         (h_side[6*UW-1:3*UW]),
		.hu         (hu),
		.ok         (h_ok & h_side[HSW-1]),
		.tex        (h_side[6*UW +: 3*CB]),
		.out_valid  (m_tvalid),
		.rgb        (rgb),
		.degenerate (m_tuser)
	);

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= n_valid;
		end
	end

	assign m_tdata = OUT_W'(rgb);

endmodule
